@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Implication checked on every rising edge of clk outside reset.
`define SLCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true on a rising edge of clk outside reset.
`define SLCFR_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SLCFR_ASSERT(lbl, prop, msg)
`define SLCFR_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

@@ src/slcfr_pkg.sv @@
// Package of the frame receiver: sizes, codes, register map and shared types.
package slcfr_pkg;

  localparam int FRAME_BUF_LEN = 32;
  localparam int BL_W          = $clog2(FRAME_BUF_LEN);
  localparam int WIN_BYTES     = 9;

  // Longest accepted length byte, one bit wider than a byte and compared with the zero-extended length byte.
  localparam logic [8:0] LEN_MAX = 9'(FRAME_BUF_LEN - 1);

  // Oldest character in the top byte, newest in the bottom byte.
  localparam logic [8*WIN_BYTES-1:0] DISC_TEXT = "Connect:0";

  // Input item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_CSUM    = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Parser phases.
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_CHK  = 2'd3;

  // Register byte addresses.
  localparam int ADDR_W = 4;
  localparam logic [ADDR_W-1:0] ADDR_START   = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_MIN_LEN = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_TIMEOUT = 4'h8;

  // Register reset values.
  localparam logic [7:0]  START_RST   = 8'd154;
  localparam logic [4:0]  MIN_LEN_RST = 5'd2;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [4:0]  min_length;
    logic [15:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic       disconnect_seen;
    logic [4:0] frame_position;
    logic [7:0] frame_byte;
    logic       frame_byte_valid;
    logic [1:0] status;
  } result_t;

endpackage

@@ src/sof_length_checksum_frame_receiver.sv @@
// Top level of the frame receiver: register port, parser and output buffering.
//
// Each input transfer is a received byte (in_tuser = 0) or a timer tick
// (in_tuser = 1) and yields exactly one result transfer. The block takes one
// item per clock: the parser computes each result combinationally, and
// results go to a two-entry output buffer (output register plus skid
// register), so in_tready stays high while one result waits and drops only
// when both entries are full. Registers are written over the APB port at 0x0
// (start byte), 0x4 (minimum length) and 0x8 (timeout in ticks).
`include "assert_macros.svh"

module sof_length_checksum_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] kind
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [2] frame_byte_valid, [10:3] frame_byte,
  // [15:11] frame_position, [16] disconnect_seen, [23:17] zero
  output logic [23:0] out_tdata,
  // Register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [slcfr_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  slcfr_pkg::cfg_t    cfg_r;
  slcfr_pkg::result_t res;
  slcfr_pkg::result_t out_r, skid_r;
  logic               out_valid_r, skid_valid_r;
  logic               in_fire, out_pop, cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= slcfr_pkg::START_RST;
      cfg_r.min_length    <= slcfr_pkg::MIN_LEN_RST;
      cfg_r.timeout_limit <= slcfr_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr)
        slcfr_pkg::ADDR_START:   cfg_r.start_byte    <= cfg_pwdata[7:0];
        slcfr_pkg::ADDR_MIN_LEN: cfg_r.min_length    <= cfg_pwdata[4:0];
        slcfr_pkg::ADDR_TIMEOUT: cfg_r.timeout_limit <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      slcfr_pkg::ADDR_START:   cfg_prdata = {24'd0, cfg_r.start_byte};
      slcfr_pkg::ADDR_MIN_LEN: cfg_prdata = {27'd0, cfg_r.min_length};
      slcfr_pkg::ADDR_TIMEOUT: cfg_prdata = {16'd0, cfg_r.timeout_limit};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_pop   = out_valid_r && out_tready;

  slcfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .kind    (in_tuser),
    .rx_byte (in_tdata),
    .cfg     (cfg_r),
    .res     (res)
  );

  // The skid register fills only when a new result arrives while the output
  // register is held; it drains into the output register first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_pop) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.disconnect_seen, out_r.frame_position,
                       out_r.frame_byte, out_r.frame_byte_valid, out_r.status};

  `SLCFR_ASSERT_NEVER(a_skid_without_out, skid_valid_r && !out_valid_r, "skid full, output empty")
  `SLCFR_ASSERT(a_fire_fills_out, in_fire && !out_valid_r |=> out_valid_r, "result lost")
  `SLCFR_ASSERT(a_stall_fills_skid, in_fire && out_valid_r && !out_tready |=> skid_valid_r, "result dropped on stall")
  `SLCFR_ASSERT_NEVER(a_echo_clean, !res.frame_byte_valid && (res.frame_byte != 8'd0 || res.frame_position != 5'd0), "echo fields set without a stored byte")

endmodule

@@ src/slcfr_parser.sv @@
// Frame parser: phase, length, checksum, idle counter and text window.
module slcfr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                kind,
  input  logic [7:0]          rx_byte,
  input  slcfr_pkg::cfg_t     cfg,
  output slcfr_pkg::result_t  res
);

  logic [1:0]                             phase_r, phase_nxt;
  logic [slcfr_pkg::BL_W-1:0]             left_r, left_nxt;
  logic [7:0]                             sum_r, sum_nxt;
  logic [4:0]                             pos_r, pos_nxt;
  logic [15:0]                            idle_r, idle_nxt;
  logic [8*slcfr_pkg::WIN_BYTES-1:0]      win_r, win_nxt;

  logic       store;
  logic [4:0] pos_base;
  logic [7:0] sum_base;
  logic       len_bad;

  assign len_bad = ({3'd0, cfg.min_length} > rx_byte) || (rx_byte < 8'd2) ||
                   ({1'b0, rx_byte} > slcfr_pkg::LEN_MAX);

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    sum_nxt   = sum_r;
    pos_nxt   = pos_r;
    idle_nxt  = idle_r;
    win_nxt   = win_r;
    store     = 1'b0;
    pos_base  = pos_r;
    sum_base  = sum_r;
    res       = '0;

    if (kind == slcfr_pkg::KIND_BYTE) begin
      win_nxt = {win_r[8*slcfr_pkg::WIN_BYTES-9:0], rx_byte};
      res.disconnect_seen = (win_nxt == slcfr_pkg::DISC_TEXT);
      case (phase_r)
        slcfr_pkg::PH_HUNT: begin
          if (rx_byte == cfg.start_byte) begin
            store     = 1'b1;
            pos_base  = 5'd0;
            sum_base  = 8'd0;
            phase_nxt = slcfr_pkg::PH_LEN;
          end
        end
        slcfr_pkg::PH_LEN: begin
          if (len_bad) begin
            phase_nxt = slcfr_pkg::PH_HUNT;
          end else begin
            store     = 1'b1;
            left_nxt  = slcfr_pkg::BL_W'(rx_byte - 8'd1);
            phase_nxt = slcfr_pkg::PH_DATA;
          end
        end
        slcfr_pkg::PH_DATA: begin
          store    = 1'b1;
          left_nxt = left_r - slcfr_pkg::BL_W'(1);
          if (left_nxt == '0) begin
            phase_nxt = slcfr_pkg::PH_CHK;
          end
        end
        default: begin
          res.status = (rx_byte == sum_r) ? slcfr_pkg::ST_OK : slcfr_pkg::ST_CSUM;
          phase_nxt  = slcfr_pkg::PH_HUNT;
        end
      endcase
    end else if (idle_r != 16'hFFFF) begin
      idle_nxt = idle_r + 16'd1;
    end

    if (store) begin
      res.frame_byte_valid = 1'b1;
      res.frame_byte       = rx_byte;
      res.frame_position   = pos_base;
      pos_nxt              = pos_base + 5'd1;
      sum_nxt              = sum_base + rx_byte;
      idle_nxt             = 16'd0;
    end

    // A frame is open in every phase but hunting.
    if (res.status == slcfr_pkg::ST_NONE && phase_nxt != slcfr_pkg::PH_HUNT &&
        idle_nxt >= cfg.timeout_limit) begin
      phase_nxt  = slcfr_pkg::PH_HUNT;
      res.status = slcfr_pkg::ST_TIMEOUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= slcfr_pkg::PH_HUNT;
      left_r  <= '0;
      sum_r   <= '0;
      pos_r   <= '0;
      idle_r  <= '0;
      win_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      sum_r   <= sum_nxt;
      pos_r   <= pos_nxt;
      idle_r  <= idle_nxt;
      win_r   <= win_nxt;
    end
  end

endmodule
